// ===== hw/rtl/tmp_pkg.sv =====
package tmp_pkg;

  localparam int WORD_W = 32;
  localparam int WIDE_W = 64;
  localparam int CLK_W  = 27;
  localparam int DIV_CNT_W = 6;   // log2(WIDE_W)
  localparam int SQ_CNT_W  = 5;   // log2(WIDE_W / 2)

  localparam logic [CLK_W-1:0] STEP_CLK_RESET = 27'd1000000;

  typedef enum logic [1:0] {
    KIND_CRUISE = 2'd0,
    KIND_PEAK   = 2'd1,
    KIND_ACCEL  = 2'd2,
    KIND_DECEL  = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,
    S_HS,
    S_ROOM,
    S_CLASS,
    S_DIV_AD,
    S_DIV_DD,
    S_SQRT,
    S_TOP,
    S_MUP,
    S_DUP,
    S_MMID,
    S_DMID,
    S_MDN,
    S_DDN,
    S_SUM,
    S_EMIT
  } state_t;

  // one planned move, speeds already clamped to the wanted speed
  typedef struct packed {
    logic [WORD_W-1:0] move_distance;
    logic [WORD_W-1:0] accel_rate;
    logic [WORD_W-1:0] wanted_speed;
    logic [WORD_W-1:0] entry_speed;
    logic [WORD_W-1:0] exit_speed;
  } move_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [WORD_W-1:0] sat32(input logic [WIDE_W-1:0] v);
    sat32 = (v[WIDE_W-1:WORD_W] != '0) ? '1 : v[WORD_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/tmp_if.sv =====
interface tmp_move_if;
  logic        valid;
  logic        ready;
  logic [31:0] move_distance;
  logic [31:0] accel_rate;
  logic [31:0] wanted_speed;
  logic [31:0] entry_speed;
  logic [31:0] exit_speed;

  modport source(output valid, move_distance, accel_rate, wanted_speed, entry_speed,
                 exit_speed, input ready);
  modport sink(input valid, move_distance, accel_rate, wanted_speed, entry_speed,
               exit_speed, output ready);
endinterface

interface tmp_profile_if;
  logic        valid;
  logic        ready;
  logic [31:0] ramp_up_distance;
  logic [31:0] ramp_down_distance;
  logic [31:0] peak_speed;
  logic [1:0]  profile_kind;
  logic [31:0] ramp_up_end_clocks;
  logic [31:0] ramp_down_start_clocks;
  logic [31:0] move_clocks;
  logic        bad_input;

  modport source(output valid, ramp_up_distance, ramp_down_distance, peak_speed,
                 profile_kind, ramp_up_end_clocks, ramp_down_start_clocks, move_clocks,
                 bad_input, input ready);
  modport sink(input valid, ramp_up_distance, ramp_down_distance, peak_speed,
               profile_kind, ramp_up_end_clocks, ramp_down_start_clocks, move_clocks,
               bad_input, output ready);
endinterface

interface tmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [26:0] step_clock_hz;

  modport source(output valid, step_clock_hz, input ready);
  modport sink(input valid, step_clock_hz, output ready);
endinterface

// ===== hw/rtl/trapezoid_motion_profile.sv =====
// Trapezoidal velocity profile planner, one move per word.
// Channels: move (sink) takes distance, acceleration, wanted/entry/exit
// speed; profile (source) returns ramp distances, peak speed, profile kind,
// the three phase clock counts and a bad-input flag; cfg (sink) writes the
// step timer rate, always ready, to be written only while no move is in flight.
// All handshakes are valid/ready, a word moves when both are high.
// Each move runs in turn through the sequencer; a zero-acceleration move
// skips the divisions and the square root, others use the serial divider
// (up to five quotients per move) and a peak move the 32-step square root.
// The planner takes a new move only after it has emitted the last; the input
// queue (QDEPTH words) keeps taking moves while the planner works and while
// a result waits.
// Receiver stall: the result holds in the output register; the planner
// stops only when it has a new result and the register is still full.
// Reset (rst, synchronous): queue empty, no result valid, step clock rate
// back to 1 MHz.
module trapezoid_motion_profile import tmp_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  tmp_move_if.sink       move,
  tmp_profile_if.source  profile,
  tmp_cfg_if.sink        cfg
);

  logic [CLK_W-1:0] step_clk;   // step timer rate in Hz
  logic             q_valid;    // a clamped move waits in the queue
  move_t            q_item;
  logic             q_pop;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // config register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_clk <= STEP_CLK_RESET;
    end else if (cfg.valid) begin
      step_clk <= cfg.step_clock_hz;
    end
  end

  // front: takes moves, clamps speeds, queues them
  tmp_front #(.QDEPTH(QDEPTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .move    (move),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // shared 64-bit serial divider
  tmp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // back: sequencer for squares, classification, ramps, sqrt and clocks
  tmp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .step_clk (step_clk),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .profile  (profile)
  );

endmodule

// ===== hw/rtl/tmp_front.sv =====
module tmp_front import tmp_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  tmp_move_if.sink   move,
  output logic       q_valid,
  output move_t      q_item,
  input  logic       q_pop
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  move_t          mem [QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  move_t          item;

  // clamp entry / exit to the wanted speed on the way in
  always_comb begin
    item.move_distance = move.move_distance;
    item.accel_rate    = move.accel_rate;
    item.wanted_speed  = move.wanted_speed;
    item.entry_speed   = (move.entry_speed > move.wanted_speed) ? move.wanted_speed
                                                                : move.entry_speed;
    item.exit_speed    = (move.exit_speed > move.wanted_speed) ? move.wanted_speed
                                                               : move.exit_speed;
  end

  assign move.ready = (count != CW'(QDEPTH));
  assign push       = move.valid && move.ready;
  assign q_valid    = (count != '0);
  assign q_item     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/tmp_div.sv =====
module tmp_div import tmp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WIDE_W-1:0]    num;
  logic [WIDE_W-1:0]    den;
  logic [WIDE_W-1:0]    rem;
  logic [WIDE_W-1:0]    quot;
  logic [WIDE_W:0]      rem_sh;
  logic [WIDE_W:0]      rem_sub;
  logic                 fits;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    rem_sh  = {rem, num[WIDE_W-1]};
    rem_sub = rem_sh - {1'b0, den};
    fits    = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(WIDE_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(WIDE_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num  <= req.num;
      den  <= req.den;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      num  <= num << 1;
      rem  <= fits ? rem_sub[WIDE_W-1:0] : rem_sh[WIDE_W-1:0];
      quot <= {quot[WIDE_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ===== hw/rtl/tmp_back.sv =====
module tmp_back import tmp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CLK_W-1:0] step_clk,
  input  logic             q_valid,
  input  move_t            q_item,
  output logic             q_pop,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp,
  tmp_profile_if.source    profile
);

  state_t state, state_next;
  logic [1:0]          cnt;
  logic [WORD_W-1:0]   d, a, r, u, v;
  logic [WIDE_W-1:0]   r2, u2, v2, adp, hs, room, vsq;
  logic                odd;
  logic [WORD_W-1:0]   ad, dd, top, cdist;
  kind_t               kind;
  logic                bad;
  logic [WIDE_W-1:0]   t_up, t_mid, t_dn;
  logic [WORD_W-1:0]   c_up, c_dn, c_tot;
  logic [WIDE_W-1:0]   sq_x, sq_r, sq_bit;
  logic [SQ_CNT_W-1:0] sq_cnt;

  // output register
  logic                out_valid;
  logic [WORD_W-1:0]   o_ad, o_dd, o_top, o_up, o_dn, o_tot;
  kind_t               o_kind;
  logic                o_bad;

  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [WIDE_W-1:0]   mul_p;
  logic                is_cruise, is_decel, is_accel;
  logic [WORD_W-1:0]   ad_clamp;
  logic [WIDE_W-1:0]   sq_try, sq_x_next, sq_r_next;
  logic                sq_ge;
  logic                emit;
  logic [WIDE_W-1:0]   sum1, sum2;

  // shared datapath helpers
  always_comb begin
    mul_p     = {{(WIDE_W-WORD_W){1'b0}}, mul_a} * {{(WIDE_W-WORD_W){1'b0}}, mul_b};
    is_cruise = (room < adp) || ((room == adp) && odd);
    is_decel  = (vsq < u2);
    is_accel  = (vsq < v2);
    ad_clamp  = (div_rsp.quot > WIDE_W'(d)) ? d : div_rsp.quot[WORD_W-1:0];
    sq_try    = sq_r + sq_bit;
    sq_ge     = (sq_x >= sq_try);
    sq_x_next = sq_ge ? (sq_x - sq_try) : sq_x;
    sq_r_next = sq_ge ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);
    sum1      = t_up + t_mid;
    sum2      = sum1 + t_dn;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (q_valid) state_next = S_SQ;
      S_SQ:     if (cnt == 2'd3) state_next = S_HS;
      S_HS:     state_next = (a == '0) ? S_SUM : S_ROOM;
      S_ROOM:   state_next = S_CLASS;
      S_CLASS: begin
        priority if (is_cruise) state_next = S_DIV_AD;
        else if (is_decel || is_accel) state_next = S_TOP;
        else state_next = S_DIV_AD;
      end
      S_DIV_AD: if (div_rsp.done) state_next = (kind == KIND_CRUISE) ? S_DIV_DD : S_SQRT;
      S_DIV_DD: if (div_rsp.done) state_next = S_TOP;
      S_SQRT:   if (sq_cnt == '0) state_next = S_TOP;
      S_TOP:    state_next = (top == '0) ? S_SUM : S_MUP;
      S_MUP:    state_next = S_DUP;
      S_DUP:    if (div_rsp.done) state_next = S_MMID;
      S_MMID:   state_next = S_DMID;
      S_DMID:   if (div_rsp.done) state_next = S_MDN;
      S_MDN:    state_next = S_DDN;
      S_DDN:    if (div_rsp.done) state_next = S_SUM;
      S_SUM:    state_next = S_EMIT;
      S_EMIT:   if (emit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop         = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = WIDE_W'({a, 1'b0});
    mul_a         = '0;
    mul_b         = '0;
    emit          = 1'b0;
    unique case (state)
      S_IDLE: q_pop = q_valid;
      S_SQ: begin
        unique case (cnt)
          2'd0: begin mul_a = r; mul_b = r; end
          2'd1: begin mul_a = u; mul_b = u; end
          2'd2: begin mul_a = v; mul_b = v; end
          default: begin mul_a = a; mul_b = d; end
        endcase
      end
      S_CLASS: begin
        if (is_cruise) begin
          div_req.start = 1'b1;
          div_req.num   = r2 - u2;
        end else if (!is_decel && !is_accel) begin
          div_req.start = 1'b1;
          div_req.num   = vsq - u2;
        end
      end
      S_DIV_AD: begin
        div_req.start = div_rsp.done && (kind == KIND_CRUISE);
        div_req.num   = r2 - v2;
      end
      S_MUP: begin
        mul_a = top - u;
        mul_b = WORD_W'(step_clk);
        div_req.start = 1'b1;
        div_req.num   = mul_p;
        div_req.den   = WIDE_W'(a);
      end
      S_MMID: begin
        mul_a = cdist;
        mul_b = WORD_W'(step_clk);
        div_req.start = 1'b1;
        div_req.num   = mul_p;
        div_req.den   = WIDE_W'(top);
      end
      S_MDN: begin
        mul_a = top - v;
        mul_b = WORD_W'(step_clk);
        div_req.start = 1'b1;
        div_req.num   = mul_p;
        div_req.den   = WIDE_W'(a);
      end
      S_EMIT: emit = !out_valid || profile.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (profile.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        d     <= q_item.move_distance;
        a     <= q_item.accel_rate;
        r     <= q_item.wanted_speed;
        u     <= q_item.entry_speed;
        v     <= q_item.exit_speed;
        cnt   <= '0;
        bad   <= 1'b0;
        ad    <= '0;
        dd    <= '0;
        top   <= q_item.wanted_speed;
        kind  <= KIND_CRUISE;
        t_up  <= '0;
        t_mid <= '0;
        t_dn  <= '0;
      end
      S_SQ: begin
        cnt <= cnt + 1'b1;
        unique case (cnt)
          2'd0: r2 <= mul_p;
          2'd1: u2 <= mul_p;
          2'd2: v2 <= mul_p;
          default: adp <= mul_p;
        endcase
      end
      S_HS: begin
        hs  <= (u2 >> 1) + (v2 >> 1) + WIDE_W'(u2[0] & v2[0]);
        odd <= u2[0] ^ v2[0];
        if (a == '0) bad <= 1'b1;
      end
      S_ROOM: begin
        room <= r2 - hs;
        vsq  <= adp + hs;
      end
      S_CLASS: begin
        priority if (is_cruise) begin
          kind <= KIND_CRUISE;
        end else if (is_decel) begin
          dd   <= d;
          top  <= u;
          kind <= KIND_DECEL;
        end else if (is_accel) begin
          ad   <= d;
          top  <= v;
          kind <= KIND_ACCEL;
        end else begin
          kind <= KIND_PEAK;
        end
        sq_x   <= vsq;
        sq_r   <= '0;
        sq_bit <= WIDE_W'(1) << (WIDE_W - 2);
        sq_cnt <= '1;
      end
      S_DIV_AD: begin
        if (div_rsp.done) begin
          if (kind == KIND_CRUISE) begin
            ad <= div_rsp.quot[WORD_W-1:0];
          end else begin
            ad <= ad_clamp;
            dd <= d - ad_clamp;
          end
        end
      end
      S_DIV_DD: if (div_rsp.done) dd <= div_rsp.quot[WORD_W-1:0];
      S_SQRT: begin
        sq_x   <= sq_x_next;
        sq_r   <= sq_r_next;
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt - 1'b1;
        if (sq_cnt == '0) top <= sq_r_next[WORD_W-1:0];
      end
      S_TOP: begin
        if (top == '0) bad <= 1'b1;
        cdist <= d - ad - dd;
      end
      S_DUP:  if (div_rsp.done) t_up  <= div_rsp.quot;
      S_DMID: if (div_rsp.done) t_mid <= div_rsp.quot;
      S_DDN:  if (div_rsp.done) t_dn  <= div_rsp.quot;
      S_SUM: begin
        c_up  <= sat32(t_up);
        c_dn  <= sat32(sum1);
        c_tot <= sat32(sum2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_ad   <= ad;
      o_dd   <= dd;
      o_top  <= top;
      o_kind <= kind;
      o_up   <= c_up;
      o_dn   <= c_dn;
      o_tot  <= c_tot;
      o_bad  <= bad;
    end
  end

  assign profile.valid                  = out_valid;
  assign profile.ramp_up_distance       = o_ad;
  assign profile.ramp_down_distance     = o_dd;
  assign profile.peak_speed             = o_top;
  assign profile.profile_kind           = o_kind;
  assign profile.ramp_up_end_clocks     = o_up;
  assign profile.ramp_down_start_clocks = o_dn;
  assign profile.move_clocks            = o_tot;
  assign profile.bad_input              = o_bad;

  a_bad_no_clocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_bad |-> (o_up == '0) && (o_dn == '0) && (o_tot == '0))
    else $error("bad move carries nonzero clock counts");

  a_clock_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (o_up <= o_dn) && (o_dn <= o_tot))
    else $error("phase clock counts out of order");

  a_decel_no_ramp_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && (o_kind == KIND_DECEL) |-> (o_ad == '0))
    else $error("decelerate-only move has a ramp-up distance");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV_AD) || (state == S_DIV_DD) || (state == S_DUP) ||
                     (state == S_DMID) || (state == S_DDN))
    else $error("quotient arrived while no one waited");

endmodule
